[sv/sab_pkg.sv]
package sab_pkg;

  localparam int MAX_LEN    = 256;
  localparam int MAX_STATES = 512;
  localparam int ALPHABET   = 26;
  localparam int ST_W       = 9;
  localparam int LEN_W      = 9;
  localparam int SYM_W      = 5;
  localparam int TR_AW      = ST_W + SYM_W;
  localparam int TR_DEPTH   = 1 << TR_AW;

  typedef logic [ST_W-1:0]  st_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [SYM_W-1:0] sym_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_CHECK, S_NEW_CLR, S_LEN_RD, S_LEN_WR, S_WALK_RD, S_WALK_CHK,
    S_ROOT_LINK, S_Q_RD, S_QLEN_RD, S_Q_CMP, S_COPY, S_QLINK_RD, S_NQLINK_WR,
    S_NPLINK_WR, S_QLINK_WR, S_REDIR_RD, S_REDIR_CHK, S_FINISH, S_EMIT
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR_ROOT, OP_ACCEPT, OP_IGNORE, OP_OVF, OP_BEGIN, OP_NEW_CLR,
    OP_LEN_RD, OP_LEN_WR, OP_WALK_RD, OP_WALK_SET, OP_ROOT_LINK, OP_Q_RD,
    OP_QLEN_RD, OP_LINK_Q, OP_CLONE_BEGIN, OP_COPY, OP_QLINK_RD, OP_NQLINK_WR,
    OP_NPLINK_WR, OP_QLINK_WR, OP_REDIR_SET, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    logic sym_bad;
    logic full;
    logic trans_zero;
    logic trans_is_q;
    logic p_root;
    logic len_match;
    logic k_last;
    logic k_full;
  } dp_status_t;

endpackage

[sv/sab_ctrl.sv]
module sab_ctrl
  import sab_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       start_new,
  input  dp_status_t status,
  output dp_op_t     op,
  output logic       busy,
  output logic       done
);

  state_t state, state_next;
  logic   pending, pending_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLR;
      pending <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
    end
  end

  assign busy = rst | (state != S_IDLE);

  always_comb begin
    state_next   = state;
    pending_next = pending;
    op           = OP_NONE;
    done         = 1'b0;
    unique case (state)
      S_CLR: begin
        op = OP_CLR_ROOT;
        if (status.k_last) state_next = pending ? S_CHECK : S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op           = OP_ACCEPT;
          pending_next = 1'b1;
          state_next   = start_new ? S_CLR : S_CHECK;
        end
      end
      S_CHECK: begin
        if (status.sym_bad) begin
          op = OP_IGNORE;
          state_next = S_EMIT;
        end else if (status.full) begin
          op = OP_OVF;
          state_next = S_EMIT;
        end else begin
          op = OP_BEGIN;
          state_next = S_NEW_CLR;
        end
      end
      S_NEW_CLR: begin
        op = OP_NEW_CLR;
        if (status.k_last) state_next = S_LEN_RD;
      end
      S_LEN_RD: begin
        op = OP_LEN_RD;
        state_next = S_LEN_WR;
      end
      S_LEN_WR: begin
        op = OP_LEN_WR;
        state_next = S_WALK_RD;
      end
      S_WALK_RD: begin
        op = OP_WALK_RD;
        state_next = S_WALK_CHK;
      end
      S_WALK_CHK: begin
        if (!status.trans_zero) begin
          state_next = S_Q_RD;
        end else begin
          op = OP_WALK_SET;
          state_next = status.p_root ? S_ROOT_LINK : S_WALK_RD;
        end
      end
      S_ROOT_LINK: begin
        op = OP_ROOT_LINK;
        state_next = S_FINISH;
      end
      S_Q_RD: begin
        op = OP_Q_RD;
        state_next = S_QLEN_RD;
      end
      S_QLEN_RD: begin
        op = OP_QLEN_RD;
        state_next = S_Q_CMP;
      end
      S_Q_CMP: begin
        if (status.len_match) begin
          op = OP_LINK_Q;
          state_next = S_FINISH;
        end else begin
          op = OP_CLONE_BEGIN;
          state_next = S_COPY;
        end
      end
      S_COPY: begin
        op = OP_COPY;
        if (status.k_full) state_next = S_QLINK_RD;
      end
      S_QLINK_RD: begin
        op = OP_QLINK_RD;
        state_next = S_NQLINK_WR;
      end
      S_NQLINK_WR: begin
        op = OP_NQLINK_WR;
        state_next = S_NPLINK_WR;
      end
      S_NPLINK_WR: begin
        op = OP_NPLINK_WR;
        state_next = S_QLINK_WR;
      end
      S_QLINK_WR: begin
        op = OP_QLINK_WR;
        state_next = S_REDIR_RD;
      end
      S_REDIR_RD: begin
        op = OP_WALK_RD;
        state_next = S_REDIR_CHK;
      end
      S_REDIR_CHK: begin
        if (!status.trans_is_q) begin
          state_next = S_FINISH;
        end else begin
          op = OP_REDIR_SET;
          state_next = status.p_root ? S_FINISH : S_REDIR_RD;
        end
      end
      S_FINISH: begin
        op = OP_FINISH;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        done         = 1'b1;
        pending_next = 1'b0;
        state_next   = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[sv/sab_dp.sv]
module sab_dp
  import sab_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  dp_op_t     op,
  input  sym_t       symbol,
  output dp_status_t status,
  output st_t        new_state,
  output len_t       new_len,
  output st_t        new_link,
  output logic       clone_made,
  output st_t        clone_state,
  output len_t       new_substrings,
  output logic       overflow
);

  logic [ST_W-1:0] tmem [TR_DEPTH];
  logic [ST_W-1:0] lmem [MAX_STATES];
  logic [LEN_W-1:0] nmem [MAX_STATES];

  st_t  trans_rd, link_rd;
  len_t len_rd;
  logic [TR_AW-1:0] tr_raddr, tr_waddr;
  st_t  tr_wdata, l_raddr, l_waddr, l_wdata, n_raddr, n_waddr;
  len_t n_wdata;
  logic tr_we, l_we, n_we;

  sym_t c, k;
  st_t  cnt, last, p, q, np, nq, link_out;
  len_t pos, len_np, len_p, link_len;
  logic cloned;

  always_ff @(posedge clk) begin
    if (tr_we) tmem[tr_waddr] <= tr_wdata;
    trans_rd <= tmem[tr_raddr];
    if (l_we) lmem[l_waddr] <= l_wdata;
    link_rd <= lmem[l_raddr];
    if (n_we) nmem[n_waddr] <= n_wdata;
    len_rd <= nmem[n_raddr];
  end

  always_comb begin
    tr_raddr = {p, c};
    tr_waddr = {p, c};
    tr_wdata = np;
    tr_we    = 1'b0;
    l_raddr  = p;
    l_waddr  = np;
    l_wdata  = '0;
    l_we     = 1'b0;
    n_raddr  = p;
    n_waddr  = np;
    n_wdata  = '0;
    n_we     = 1'b0;
    case (op)
      OP_CLR_ROOT: begin
        tr_waddr = {ST_W'(0), k};
        tr_wdata = '0;
        tr_we    = 1'b1;
        l_waddr  = '0;
        l_we     = 1'b1;
        n_waddr  = '0;
        n_we     = 1'b1;
      end
      OP_NEW_CLR: begin
        tr_waddr = {np, k};
        tr_wdata = '0;
        tr_we    = 1'b1;
      end
      OP_LEN_WR: begin
        n_wdata = len_rd + LEN_W'(1);
        n_we    = 1'b1;
      end
      OP_WALK_SET: tr_we = 1'b1;
      OP_ROOT_LINK: l_we = 1'b1;
      OP_QLEN_RD: n_raddr = q;
      OP_LINK_Q: begin
        l_wdata = q;
        l_we    = 1'b1;
      end
      OP_CLONE_BEGIN: begin
        n_waddr = cnt + ST_W'(1);
        n_wdata = len_p + LEN_W'(1);
        n_we    = 1'b1;
      end
      OP_COPY: begin
        tr_raddr = {q, k};
        tr_waddr = {nq, k - SYM_W'(1)};
        tr_wdata = trans_rd;
        tr_we    = (k != '0);
      end
      OP_QLINK_RD: l_raddr = q;
      OP_NQLINK_WR: begin
        l_waddr = nq;
        l_wdata = link_rd;
        l_we    = 1'b1;
      end
      OP_NPLINK_WR: begin
        l_wdata = nq;
        l_we    = 1'b1;
      end
      OP_QLINK_WR: begin
        l_waddr = q;
        l_wdata = nq;
        l_we    = 1'b1;
      end
      OP_REDIR_SET: begin
        tr_wdata = nq;
        tr_we    = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      cnt  <= '0;
      last <= '0;
      pos  <= '0;
    end else begin
      case (op)
        OP_CLR_ROOT: begin
          k    <= status.k_last ? '0 : k + SYM_W'(1);
          cnt  <= '0;
          last <= '0;
          pos  <= '0;
        end
        OP_BEGIN: begin
          pos <= pos + LEN_W'(1);
          cnt <= cnt + ST_W'(1);
          k   <= '0;
        end
        OP_NEW_CLR: k <= status.k_last ? '0 : k + SYM_W'(1);
        OP_CLONE_BEGIN: begin
          cnt <= cnt + ST_W'(1);
          k   <= '0;
        end
        OP_COPY: k <= status.k_full ? '0 : k + SYM_W'(1);
        OP_FINISH: last <= np;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_ACCEPT: c <= symbol;
      OP_BEGIN: begin
        p      <= last;
        np     <= cnt + ST_W'(1);
        cloned <= 1'b0;
        nq     <= '0;
      end
      OP_LEN_WR: len_np <= len_rd + LEN_W'(1);
      OP_WALK_SET, OP_REDIR_SET: p <= link_rd;
      OP_ROOT_LINK: begin
        link_out <= '0;
        link_len <= '0;
      end
      OP_Q_RD: q <= trans_rd;
      OP_QLEN_RD: len_p <= len_rd;
      OP_LINK_Q: begin
        link_out <= q;
        link_len <= len_rd;
      end
      OP_CLONE_BEGIN: begin
        nq       <= cnt + ST_W'(1);
        cloned   <= 1'b1;
        link_out <= cnt + ST_W'(1);
        link_len <= len_p + LEN_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_IGNORE, OP_OVF: begin
        new_state      <= '0;
        new_len        <= '0;
        new_link       <= '0;
        clone_made     <= 1'b0;
        clone_state    <= '0;
        new_substrings <= '0;
        overflow       <= (op == OP_OVF);
      end
      OP_FINISH: begin
        new_state      <= np;
        new_len        <= len_np;
        new_link       <= link_out;
        clone_made     <= cloned;
        clone_state    <= nq;
        new_substrings <= len_np - link_len;
        overflow       <= 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    status.sym_bad    = (c >= SYM_W'(ALPHABET));
    status.full       = (pos >= LEN_W'(MAX_LEN)) ||
                        ({1'b0, cnt} + (ST_W+1)'(2) >= (ST_W+1)'(MAX_STATES));
    status.trans_zero = (trans_rd == '0);
    status.trans_is_q = (trans_rd == q);
    status.p_root     = (p == '0);
    status.len_match  = (len_p + LEN_W'(1) == len_rd);
    status.k_last     = (k == SYM_W'(ALPHABET - 1));
    status.k_full     = (k == SYM_W'(ALPHABET));
  end

endmodule

[sv/suffix_automaton_builder.sv]
// Online suffix automaton builder. Pulse start with busy low to hand in one item
// (start_new, symbol); the result appears later for exactly one cycle with done
// high and cannot be held off. An ignored symbol or an overflow item goes from the
// check straight to the result. Otherwise an item runs a row clear for the new
// state and a suffix-link walk that ends at the root or stops short of it, each
// step a read on the transition memory's single read port; when a clone is made
// it adds a row copy, a link read and three link writes, and a walk that
// redirects transitions to the clone. Walks grow with the text, so long
// repetitive texts take longer per item. start_new adds a root row clear first.
// After reset the block stays busy while it clears the root row.
module suffix_automaton_builder
  import sab_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic start_new,
  input  sym_t symbol,
  output logic done,
  output st_t  new_state,
  output len_t new_len,
  output st_t  new_link,
  output logic clone_made,
  output st_t  clone_state,
  output len_t new_substrings,
  output logic overflow
);

  dp_op_t     op;
  dp_status_t status;

  sab_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_new (start_new),
    .status    (status),
    .op        (op),
    .busy      (busy),
    .done      (done)
  );

  sab_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (op),
    .symbol         (symbol),
    .status         (status),
    .new_state      (new_state),
    .new_len        (new_len),
    .new_link       (new_link),
    .clone_made     (clone_made),
    .clone_state    (clone_state),
    .new_substrings (new_substrings),
    .overflow       (overflow)
  );

endmodule

[sv/sab_checker.sv]
module sab_checker
  import sab_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input st_t  new_state,
  input st_t  new_link,
  input logic clone_made,
  input st_t  clone_state,
  input logic overflow
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("no busy after item");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");

  a_overflow_zero: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> new_state == '0 && clone_made == 1'b0)
    else $error("overflow item not empty");

  a_clone_link: assert property (@(posedge clk) disable iff (rst)
    done && clone_made |-> clone_state == new_state + ST_W'(1) &&
                           new_link == clone_state)
    else $error("clone fields wrong");

endmodule

bind suffix_automaton_builder sab_checker u_sab_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .new_state   (new_state),
  .new_link    (new_link),
  .clone_made  (clone_made),
  .clone_state (clone_state),
  .overflow    (overflow)
);
